/* rtl/core/mcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mcd_pkg;

  // default sizing
  localparam int MCD_COUNT_BITS = 24;
  localparam int MCD_FRAC_BITS  = 8;

  // width of the sum of three squared 8-bit differences
  localparam int MCD_SUMSQ_BITS = 18;
  // largest sum of squares, 3 * 255 * 255
  localparam logic [MCD_SUMSQ_BITS-1:0] MCD_MAX_SUMSQ = 18'd195075;

  // width of the mean result
  localparam int MCD_QUOT_BITS = 16;

  // control travelling along the root cells
  typedef struct packed {
    logic valid;
    logic last;
  } mcd_ctl_t;

  // result handshake from the divider
  typedef struct packed {
    logic busy;
    logic done;
  } mcd_div_stat_t;

  // integer square root, used at elaboration for the normalization constant
  function automatic logic [63:0] mcd_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mcd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// one digit of a restoring square root, registered
module mcd_cell
  import mcd_pkg::*;
#(
  parameter int RB = 17
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mcd_ctl_t          ctl_i,
  input  wire logic [2*RB-1:0]   v_i,
  input  wire logic [RB+1:0]     rem_i,
  input  wire logic [RB-1:0]     root_i,
  output mcd_ctl_t               ctl_o,
  output logic      [2*RB-1:0]   v_o,
  output logic      [RB+1:0]     rem_o,
  output logic      [RB-1:0]     root_o
);

  logic [RB+1:0] rem_sh;
  logic [RB+1:0] trial;
  logic          take;

  mcd_ctl_t      ctl_q;
  logic [2*RB-1:0] v_q;
  logic [RB+1:0] rem_q;
  logic [RB-1:0] root_q;

  always_comb begin
    rem_sh = {rem_i[RB-1:0], v_i[2*RB-1 -: 2]};
    trial  = {root_i, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= {v_i[2*RB-3:0], 2'b00};
    rem_q  <= take ? (rem_sh - trial) : rem_sh;
    root_q <= {root_i[RB-2:0], take};
  end

  assign ctl_o  = ctl_q;
  assign v_o    = v_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* rtl/core/mcd_divider.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle, saturating
module mcd_divider
  import mcd_pkg::*;
#(
  parameter int SW = 41,
  parameter int DW = 42
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [SW-1:0]            sum_i,
  input  wire logic [DW-1:0]            den_i,
  output mcd_div_stat_t                 stat_o,
  output logic      [MCD_QUOT_BITS-1:0] quot_o
);

  localparam int StepW = $clog2(MCD_QUOT_BITS + 1);

  logic                     busy_q;
  logic                     done_q;
  logic [StepW-1:0]         step_q;
  logic [DW:0]              rem_q;
  logic [DW-1:0]            den_q;
  logic [MCD_QUOT_BITS-1:0] quot_q;

  logic [DW:0] rem_sh;
  logic        take;

  always_comb begin
    rem_sh = {rem_q[DW-1:0], 1'b0};
    take   = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if ({{(DW-SW){1'b0}}, sum_i} >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          step_q <= StepW'(MCD_QUOT_BITS);
        end
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {{(DW+1-SW){1'b0}}, sum_i};
      den_q  <= den_i;
      quot_q <= '1;
    end else if (busy_q) begin
      rem_q  <= take ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quot_q <= {quot_q[MCD_QUOT_BITS-2:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

`default_nettype wire

/* rtl/core/mean_color_distance_accumulator.sv */
`timescale 1ns / 1ps
`default_nettype none

// mean color distance accumulator
//
// slave stream: one beat per pixel pair, tdata holds from the lowest bit up
// ref_ch0, ref_ch1, ref_ch2, test_ch0, test_ch1, test_ch2 (8 bits each);
// tlast marks the final pixel of an image.
// master stream: one beat per image, tdata holds mean_distance (16 bits,
// 65535 stands for distance one) then pixel_total (COUNT_BITS+1 bits).
//
// pixels are taken one per cycle while the slave side is open. the per-pixel
// distance root is built by a row of 9+FRAC_BITS root cells, one result bit
// per cell; a pixel passes the input register and every cell to the accumulator.
// after the tlast beat the slave side stays closed until the result beat is
// taken: the row drains, S_MUL forms the divisor, S_START starts the divider,
// which makes one quotient bit per cycle (none when the mean saturates), and
// S_DIV loads the result when the divider is done, after which tvalid rises.
// the result beat is held in an output register while the receiver stalls;
// the accumulator clears when it is taken.
// reset clears the accumulator, pixel counter and control, including the valid flags of the cell row.
// once 2^COUNT_BITS pixels are held, further pixels are not counted.
module mean_color_distance_accumulator
  import mcd_pkg::*;
#(
  parameter int COUNT_BITS = MCD_COUNT_BITS,
  parameter int FRAC_BITS  = MCD_FRAC_BITS,
  localparam int CW = COUNT_BITS + 1,
  localparam int OW = ((MCD_QUOT_BITS + CW) + 7) / 8 * 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // ref_ch0, ref_ch1, ref_ch2, test_ch0, test_ch1, test_ch2
  input  wire logic [47:0]   s_axis_tdata_i,
  input  wire logic          s_axis_tlast_i,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // mean_distance, pixel_total
  output logic      [OW-1:0] m_axis_tdata_o,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i
);

  // root bits, one cell each
  localparam int RB = MCD_SUMSQ_BITS / 2 + FRAC_BITS;
  localparam int VW = 2 * RB;
  localparam int SW = COUNT_BITS + RB;
  localparam int DW = CW + RB;
  localparam logic [RB-1:0] NORM =
      RB'(mcd_isqrt(64'(MCD_MAX_SUMSQ) << (2 * FRAC_BITS)));
  localparam logic [CW-1:0] CNT_LIMIT = {1'b1, {COUNT_BITS{1'b0}}};

  typedef enum logic [4:0] {
    S_RUN   = 5'b00001,
    S_MUL   = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  state_e state_q, state_d;
  logic   closing_q;

  logic [7:0]  d0, d1, d2;
  logic [MCD_SUMSQ_BITS-1:0] sumsq_d;
  logic [MCD_SUMSQ_BITS-1:0] sumsq_q;
  mcd_ctl_t    in_ctl_q;

  // cell row taps
  mcd_ctl_t      ctl_w  [RB+1];
  logic [VW-1:0] v_w    [RB+1];
  logic [RB+1:0] rem_w  [RB+1];
  logic [RB-1:0] root_w [RB+1];

  logic [SW-1:0] sum_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] den_q;

  mcd_div_stat_t            div_stat;
  logic [MCD_QUOT_BITS-1:0] div_quot;

  logic [MCD_QUOT_BITS-1:0] mean_q;
  logic [CW-1:0]            total_q;

  logic in_fire, out_fire;

  assign s_axis_tready_o = (state_q == S_RUN) && !closing_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;

  // front end: channel differences and sum of squares
  always_comb begin
    d0 = abs_diff(s_axis_tdata_i[7:0],   s_axis_tdata_i[31:24]);
    d1 = abs_diff(s_axis_tdata_i[15:8],  s_axis_tdata_i[39:32]);
    d2 = abs_diff(s_axis_tdata_i[23:16], s_axis_tdata_i[47:40]);
    sumsq_d = MCD_SUMSQ_BITS'(16'(d0 * d0)) + MCD_SUMSQ_BITS'(16'(d1 * d1))
            + MCD_SUMSQ_BITS'(16'(d2 * d2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else begin
      in_ctl_q.valid <= in_fire;
      in_ctl_q.last  <= in_fire && s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sumsq_q <= sumsq_d;
    end
  end

  // head of the root row: value is sumsq scaled by 2^(2*FRAC_BITS)
  assign ctl_w[0]  = in_ctl_q;
  assign v_w[0]    = {sumsq_q, {(2 * FRAC_BITS){1'b0}}};
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar g = 0; g < RB; g++) begin : g_cell
    mcd_cell #(
      .RB(RB)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_w[g]),
      .v_i    (v_w[g]),
      .rem_i  (rem_w[g]),
      .root_i (root_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .v_o    (v_w[g+1]),
      .rem_o  (rem_w[g+1]),
      .root_o (root_w[g+1])
    );
  end

  // frame control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_RUN:   if (ctl_w[RB].valid && ctl_w[RB].last) state_d = S_MUL;
      S_MUL:   state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV:   if (div_stat.done) state_d = S_OUT;
      S_OUT:   if (m_axis_tready_i) state_d = S_RUN;
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RUN;
      closing_q <= 1'b0;
      sum_q     <= '0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire && s_axis_tlast_i) begin
        closing_q <= 1'b1;
      end else if (out_fire) begin
        closing_q <= 1'b0;
      end
      // accumulate roots leaving the row, up to the counter limit
      if (out_fire) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else if (ctl_w[RB].valid && (cnt_q < CNT_LIMIT)) begin
        sum_q <= sum_q + SW'(root_w[RB]);
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // divisor = count * normalization
  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      den_q <= DW'(cnt_q * NORM);
    end
  end

  mcd_divider #(
    .SW(SW),
    .DW(DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_START),
    .sum_i   (sum_q),
    .den_i   (den_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // result register, held while the receiver stalls
  always_ff @(posedge clk_i) begin
    if ((state_q == S_DIV) && div_stat.done) begin
      mean_q  <= div_quot;
      total_q <= cnt_q;
    end
  end

  assign m_axis_tdata_o = OW'({total_q, mean_q});

`ifndef SYNTHESIS
  // the row is empty once the frame has left it
  a_row_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_w[RB].valid |-> (state_q == S_RUN))
    else $error("pixel left the root row outside accumulation");

  // the counter never passes its limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_LIMIT)
    else $error("pixel counter above limit");

  // a result beat follows a divider completion
  a_out_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(div_stat.done))
    else $error("result beat without divider completion");

  // divider is never busy while pixels are taken
  a_div_idle_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !div_stat.busy)
    else $error("pixel accepted while divider busy");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import mcd_pkg::*;

  localparam int CNT_W  = MCD_COUNT_BITS + 1;
  localparam int OUT_W  = ((MCD_QUOT_BITS + CNT_W) + 7) / 8 * 8;
  localparam int PAD_LO = MCD_QUOT_BITS + CNT_W;

  // one pixel pair, ref_ch0 in the lowest byte as on the slave tdata
  typedef struct packed {
    logic [7:0] test_ch2;
    logic [7:0] test_ch1;
    logic [7:0] test_ch0;
    logic [7:0] ref_ch2;
    logic [7:0] ref_ch1;
    logic [7:0] ref_ch0;
  } pixel_pair_t;

  typedef struct {
    logic [MCD_QUOT_BITS-1:0] mean_distance;
    logic [CNT_W-1:0]         pixel_total;
  } image_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic [47:0]      s_axis_tdata_i;
  logic             s_axis_tlast_i;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;

  mean_color_distance_accumulator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  // predicted state of the accumulator
  logic [63:0]   dist_sum_acc;
  logic [63:0]   pix_count;
  logic [63:0]   norm_q8;
  image_result_t image_mean_q[$];
  image_result_t got_mean;

  int unsigned fail_count;
  int unsigned pixels_sent;
  int unsigned images_checked;
  int unsigned full_scale_seen;
  int unsigned gap_pct;
  int unsigned stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // floor(sqrt(sumsq << 2*frac)), built bit by bit from the top
  function automatic logic [63:0] dist_root(input logic [63:0] sumsq);
    logic [63:0] target;
    logic [63:0] root;
    logic [63:0] trial;
    target = sumsq << (2 * MCD_FRAC_BITS);
    root   = '0;
    for (int k = 24; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= target) root = trial;
    end
    return root;
  endfunction

  function automatic logic [63:0] chan_diff_sq(input logic [7:0] a, input logic [7:0] b);
    logic [63:0] d;
    d = (a > b) ? 64'(a - b) : 64'(b - a);
    return d * d;
  endfunction

  // fold one accepted beat into the predicted accumulator
  task automatic absorb_pixel(input pixel_pair_t p, input logic last);
    logic [63:0]   sumsq;
    logic [63:0]   den;
    image_result_t r;
    sumsq = chan_diff_sq(p.ref_ch0, p.test_ch0) + chan_diff_sq(p.ref_ch1, p.test_ch1)
          + chan_diff_sq(p.ref_ch2, p.test_ch2);
    // counter saturation: pixels past 2^COUNT_BITS are dropped
    if (pix_count < (64'd1 << MCD_COUNT_BITS)) begin
      dist_sum_acc += dist_root(sumsq);
      pix_count    += 64'd1;
    end
    if (last) begin
      den = pix_count * norm_q8;
      if (den == 0 || dist_sum_acc >= den) r.mean_distance = '1;
      else r.mean_distance = MCD_QUOT_BITS'((dist_sum_acc << 16) / den);
      r.pixel_total = CNT_W'(pix_count);
      image_mean_q = {image_mean_q, r};
      dist_sum_acc = '0;
      pix_count    = '0;
    end
  endtask

  // drive one beat, maybe after an idle burst, and wait for it to be taken
  task automatic send_pixel(input pixel_pair_t p, input logic last);
    @(negedge clk_i);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_axis_tdata_i  = p;
    s_axis_tlast_i  = last;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    absorb_pixel(p, last);
    pixels_sent++;
  endtask

  function automatic pixel_pair_t make_pixel(input int unsigned flavor);
    pixel_pair_t p;
    p = 48'({$urandom, $urandom});
    case (flavor)
      1: begin  // small differences
        p.test_ch0 = p.ref_ch0 ^ 8'($urandom_range(0, 3));
        p.test_ch1 = p.ref_ch1 ^ 8'($urandom_range(0, 3));
        p.test_ch2 = p.ref_ch2 ^ 8'($urandom_range(0, 3));
      end
      2: begin  // channels at the rails, in any mix
        p.ref_ch0  = {8{p.ref_ch0[0]}};
        p.ref_ch1  = {8{p.ref_ch1[0]}};
        p.ref_ch2  = {8{p.ref_ch2[0]}};
        p.test_ch0 = {8{p.test_ch0[0]}};
        p.test_ch1 = {8{p.test_ch1[0]}};
        p.test_ch2 = {8{p.test_ch2[0]}};
      end
      3: begin  // identical pair
        p.test_ch0 = p.ref_ch0;
        p.test_ch1 = p.ref_ch1;
        p.test_ch2 = p.ref_ch2;
      end
      4: begin  // largest distance, either direction per channel
        p.ref_ch0  = {8{p.ref_ch0[0]}};
        p.ref_ch1  = {8{p.ref_ch1[0]}};
        p.ref_ch2  = {8{p.ref_ch2[0]}};
        p.test_ch0 = ~p.ref_ch0;
        p.test_ch1 = ~p.ref_ch1;
        p.test_ch2 = ~p.ref_ch2;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_image(input int unsigned len, input bit full_scale);
    int unsigned flavor;
    for (int unsigned i = 0; i < len; i++) begin
      flavor = $urandom_range(0, 9);
      if (full_scale) flavor = 4;
      else if (flavor < 5) flavor = 0;
      else if (flavor < 7) flavor = 1;
      else if (flavor < 9) flavor = 2;
      else flavor = 3;
      send_pixel(make_pixel(flavor), i == len - 1);
    end
  endtask

  // stop offering the last beat, then wait for every pending result
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (image_mean_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: ready with random stall bursts
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // result beats against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (image_mean_q.size() == 0) begin
        $error("result beat with no image pending: tdata %h", m_axis_tdata_o);
        fail_count++;
      end else begin
        got_mean = image_mean_q.pop_front();
        images_checked++;
        if (m_axis_tdata_o[MCD_QUOT_BITS-1:0] == '1) full_scale_seen++;
        if (m_axis_tdata_o[MCD_QUOT_BITS-1:0] !== got_mean.mean_distance) begin
          $error("mean_distance: expected %0d, actual %0d", got_mean.mean_distance,
                 m_axis_tdata_o[MCD_QUOT_BITS-1:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[PAD_LO-1:MCD_QUOT_BITS] !== got_mean.pixel_total) begin
          $error("pixel_total: expected %0d, actual %0d", got_mean.pixel_total,
                 m_axis_tdata_o[PAD_LO-1:MCD_QUOT_BITS]);
          fail_count++;
        end
        if (m_axis_tdata_o[OUT_W-1:PAD_LO] !== '0) begin
          $error("tdata padding: expected 0, actual %h", m_axis_tdata_o[OUT_W-1:PAD_LO]);
          fail_count++;
        end
      end
    end
  end

  // single-pixel images at the edges, each channel alone, then short mixed images
  task automatic test_directed();
    pixel_pair_t p;
    p = {8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128};
    send_pixel(p, 1'b1);                          // zero distance
    p = {8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
    send_pixel(p, 1'b1);                          // full scale, test above ref
    p = {8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255};
    send_pixel(p, 1'b1);                          // full scale, ref above test
    p = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255};
    send_pixel(p, 1'b1);                          // channel 0 only
    p = {8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
    send_pixel(p, 1'b1);                          // channel 1 only
    p = {8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0};
    send_pixel(p, 1'b1);                          // channel 2 only
    p = {8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0};
    send_pixel(p, 1'b1);                          // smallest nonzero distance
    p = {8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA};
    send_pixel(p, 1'b1);                          // alternating bit patterns
    p = ~p;
    send_pixel(p, 1'b1);
    // all full scale over several pixels: mean pinned at the top
    for (int i = 0; i < 4; i++) send_pixel(make_pixel(4), i == 3);
    // full scale mixed with a zero pixel: mean at three quarters of the top
    for (int i = 0; i < 3; i++) send_pixel(make_pixel(4), 1'b0);
    send_pixel(make_pixel(3), 1'b1);
    // all zero distance over several pixels
    for (int i = 0; i < 3; i++) send_pixel(make_pixel(3), i == 2);
    p = {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    send_pixel(p, 1'b1);
  endtask

  // sender holds off until each image's result is back
  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++) begin
      send_image($urandom_range(1, 12), 1'b0);
      wait_results_drained();
    end
  endtask

  // random images of mostly short length, some long, with idle bursts on both sides
  task automatic test_random_images(input int unsigned pixel_budget);
    int unsigned start;
    int unsigned len;
    start = pixels_sent;
    while (pixels_sent - start < pixel_budget) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 50;
      endcase
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
      send_image(len, $urandom_range(0, 11) == 0);
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate(input int unsigned pixel_budget);
    int unsigned start;
    gap_pct   = 0;
    stall_pct = 0;
    start     = pixels_sent;
    while (pixels_sent - start < pixel_budget)
      send_image($urandom_range(1, 30), $urandom_range(0, 11) == 0);
  endtask

  initial begin
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    s_axis_tvalid_i = 1'b0;
    rst_ni          = 1'b0;
    fail_count      = 0;
    pixels_sent     = 0;
    images_checked  = 0;
    full_scale_seen = 0;
    gap_pct         = 0;
    stall_pct       = 0;
    dist_sum_acc    = '0;
    pix_count       = '0;
    norm_q8         = dist_root(64'(MCD_MAX_SUMSQ));
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    gap_pct   = 20;
    stall_pct = 20;
    test_drain_pause();
    test_random_images(1450);
    test_full_rate(250);

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    s_axis_tlast_i  = 1'b0;
    wait_results_drained();
    repeat (60) @(posedge clk_i);
    if (image_mean_q.size() != 0) begin
      $error("%0d image results never arrived", image_mean_q.size());
      fail_count++;
    end

    $display("covered %0d pixel beats in %0d images, %0d of them at full-scale distance",
             pixels_sent, images_checked, full_scale_seen);
    $display("idle bursts on both sides, a drain pause, and a closing full-rate stretch");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mcd_pkg.sv
rtl/core/mcd_cell.sv
rtl/core/mcd_divider.sv
rtl/core/mean_color_distance_accumulator.sv
tb/tb.sv
